/* hdl/lzwh_pkg.sv */
// Shared types, constants and decode functions for the LZW hash compressor.
`timescale 1ns / 1ps
`default_nettype none

package lzwh_pkg;

    localparam int HASH_ENTRIES_DEF = 78649;
    localparam int FIRST_FREE_DEF   = 257;

    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 16;
    localparam int NEXT_W     = 17;
    localparam int BITS_W     = 5;
    localparam int SHAMT_W    = 4;
    localparam int SIZE_TBL_W = 17;
    localparam int EPOCH_W    = 8;
    localparam int MCNT_W     = $clog2(CODE_W);

    localparam logic [BITS_W-1:0] BITS_MIN   = BITS_W'(9);
    localparam logic [BITS_W-1:0] BITS_MAX   = BITS_W'(16);
    localparam logic [BITS_W-1:0] BITS_RESET = BITS_W'(16);

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [CODE_W-1:0]  prefix;
        logic [BYTE_W-1:0]  data_byte;
        logic [CODE_W-1:0]  code;
    } t_dict_entry;

    function automatic logic [BITS_W-1:0] eff_bits(input logic [BITS_W-1:0] raw);
        logic [BITS_W-1:0] eff;
        eff = raw;
        if (raw < BITS_MIN) begin
            eff = BITS_MIN;
        end else if (raw > BITS_MAX) begin
            eff = BITS_MAX;
        end
        return eff;
    endfunction

    function automatic logic [SIZE_TBL_W-1:0] table_size(input logic [BITS_W-1:0] eff);
        logic [SIZE_TBL_W-1:0] sz;
        unique case (eff)
            BITS_W'(9):  sz = SIZE_TBL_W'(641);
            BITS_W'(10): sz = SIZE_TBL_W'(1259);
            BITS_W'(11): sz = SIZE_TBL_W'(2459);
            BITS_W'(12): sz = SIZE_TBL_W'(4919);
            BITS_W'(13): sz = SIZE_TBL_W'(9833);
            BITS_W'(14): sz = SIZE_TBL_W'(19661);
            BITS_W'(15): sz = SIZE_TBL_W'(39323);
            default:     sz = SIZE_TBL_W'(78649);
        endcase
        return sz;
    endfunction

    function automatic logic [SHAMT_W-1:0] hash_shift(input logic [BITS_W-1:0] eff);
        return SHAMT_W'(eff - BITS_W'(BYTE_W));
    endfunction

    function automatic logic [NEXT_W-1:0] code_limit(input logic [BITS_W-1:0] eff);
        return NEXT_W'((NEXT_W'(1) << eff) - NEXT_W'(1));
    endfunction

endpackage

`default_nettype wire

/* hdl/lzwh_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lzwh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/lzw_hash_compressor.sv */
// LZW compressor with an open-addressed hash dictionary, one byte per word.
//
//  channel  | signals                                    | dir | handshake
//  ---------+--------------------------------------------+-----+--------------------
//  cfg      | i_cfg_we, i_cfg_data                       | in  | write when i_cfg_we
//  in       | i_in_valid, o_in_stall, i_data_byte,       | in  | valid & !stall
//           | i_end_of_data                              |     |
//  out      | o_out_valid, i_out_stall, o_code_out,      | out | valid & !stall
//           | o_final_code                               |     |
//
// A byte passes accept, RAM read and compare on a first-probe hit, and on a first-probe
// miss also loads the output register; each further probe goes again through RAM read
// and compare on the single dictionary read port. When HASH_ENTRIES is below the table
// size for the code width, a hash that lands at or above it first passes through the
// bit-serial remainder unit. A last byte then goes through the final code state.
// After reset, and after every 255th stream restart or register write, a clearing
// pass sweeps every dictionary entry; no byte is taken meanwhile.
// A stalled output holds the block in its emit or final state until the word is taken.
`timescale 1ns / 1ps
`default_nettype none

module lzw_hash_compressor #(
    parameter int HASH_ENTRIES    = lzwh_pkg::HASH_ENTRIES_DEF,
    parameter int FIRST_FREE_CODE = lzwh_pkg::FIRST_FREE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lzwh_pkg::BITS_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lzwh_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_end_of_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lzwh_pkg::CODE_W-1:0] o_code_out,
    output logic                        o_final_code
);

    localparam int AW      = $clog2(HASH_ENTRIES);
    localparam int SW      = $clog2(HASH_ENTRIES + 1);
    localparam int DW      = SW + 1;
    localparam int XW      = lzwh_pkg::NEXT_W;
    localparam int CODE_W  = lzwh_pkg::CODE_W;
    localparam int BYTE_W  = lzwh_pkg::BYTE_W;
    localparam int NEXT_W  = lzwh_pkg::NEXT_W;
    localparam int EPOCH_W = lzwh_pkg::EPOCH_W;
    localparam int MCNT_W  = lzwh_pkg::MCNT_W;
    localparam int EW      = $bits(lzwh_pkg::t_dict_entry);

    localparam int RST_TBL = int'(lzwh_pkg::table_size(lzwh_pkg::BITS_RESET));
    localparam logic [SW-1:0] RST_SIZE =
        SW'((RST_TBL > HASH_ENTRIES) ? HASH_ENTRIES : RST_TBL);
    localparam logic [lzwh_pkg::SHAMT_W-1:0] RST_SHAMT =
        lzwh_pkg::hash_shift(lzwh_pkg::BITS_RESET);
    localparam logic [NEXT_W-1:0] RST_LIMIT = lzwh_pkg::code_limit(lzwh_pkg::BITS_RESET);
    localparam logic [NEXT_W-1:0] FREE_CODE_INIT = NEXT_W'(FIRST_FREE_CODE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HASH_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_EMIT,
        S_FINAL
    } t_state;

    t_state                          r_state;
    logic [lzwh_pkg::SHAMT_W-1:0]    r_shamt;
    logic [SW-1:0]                   r_size;
    logic [NEXT_W-1:0]               r_limit;
    logic [CODE_W-1:0]               r_prefix;
    logic                            r_have;
    logic [NEXT_W-1:0]               r_next_free;
    logic [EPOCH_W-1:0]              r_epoch;
    logic [AW-1:0]                   r_clr_addr;
    logic [AW-1:0]                   r_slot;
    logic [AW-1:0]                   r_step;
    logic [SW-1:0]                   r_n;
    logic [SW-1:0]                   r_rem;
    logic [MCNT_W-1:0]               r_mcnt;
    logic [CODE_W-1:0]               r_h;
    logic [BYTE_W-1:0]               r_k;
    logic                            r_last;
    logic [CODE_W-1:0]               r_emit_code;
    logic                            r_out_valid;
    logic [CODE_W-1:0]               r_out_code;
    logic                            r_out_final;

    logic [lzwh_pkg::BITS_W-1:0]     cfg_eff;
    logic [lzwh_pkg::SIZE_TBL_W-1:0] cfg_tbl;
    logic [SW-1:0]                   cfg_size;
    logic [CODE_W-1:0]               hash_v;
    logic                            hash_fits;
    logic [DW-1:0]                   sub_a;
    logic [DW-1:0]                   sub_b;
    logic [DW-1:0]                   sub_diff;
    logic                            sub_ge;
    logic [SW-1:0]                   n_rem;
    logic [AW-1:0]                   n_slot;
    logic [SW-1:0]                   n_n;
    logic                            can_load;
    logic                            out_load;
    logic                            epoch_wrap;
    lzwh_pkg::t_dict_entry           rd_entry;
    lzwh_pkg::t_dict_entry           wr_entry;
    logic [EW-1:0]                   ram_rdata;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic                            slot_free;
    logic                            slot_hit;
    logic                            can_insert;

    assign cfg_eff  = lzwh_pkg::eff_bits(i_cfg_data);
    assign cfg_tbl  = lzwh_pkg::table_size(cfg_eff);
    assign cfg_size = (cfg_tbl > lzwh_pkg::SIZE_TBL_W'(HASH_ENTRIES)) ?
                      SW'(HASH_ENTRIES) : SW'(cfg_tbl);

    assign hash_v    = CODE_W'({{BYTE_W{1'b0}}, i_data_byte} << r_shamt) ^ r_prefix;
    assign hash_fits = XW'(hash_v) < XW'(r_size);

    // Shared subtract/compare unit: remainder step, probe step, probe advance.
    always_comb begin
        unique case (r_state)
            S_MOD: begin
                sub_a = {r_rem, r_h[r_mcnt]};
                sub_b = DW'(r_size);
            end
            S_READ: begin
                sub_a = DW'(r_size);
                sub_b = DW'(r_slot);
            end
            default: begin
                sub_a = DW'(r_slot);
                sub_b = DW'(r_step);
            end
        endcase
    end

    assign sub_diff = sub_a - sub_b;
    assign sub_ge   = sub_a >= sub_b;
    assign n_rem    = sub_ge ? sub_diff[SW-1:0] : sub_a[SW-1:0];
    assign n_slot   = sub_ge ? sub_diff[AW-1:0] : AW'(sub_diff + DW'(r_size));
    assign n_n      = SW'(r_n + SW'(1));

    assign rd_entry   = lzwh_pkg::t_dict_entry'(ram_rdata);
    assign slot_free  = rd_entry.epoch != r_epoch;
    assign slot_hit   = (rd_entry.prefix == r_prefix) && (rd_entry.data_byte == r_k);
    assign can_insert = r_next_free < r_limit;
    assign can_load   = !r_out_valid || !i_out_stall;
    assign out_load   = !i_cfg_we && can_load && (r_state == S_EMIT || r_state == S_FINAL);
    assign epoch_wrap = r_epoch == {EPOCH_W{1'b1}};

    always_comb begin
        wr_entry.epoch     = r_epoch;
        wr_entry.prefix    = r_prefix;
        wr_entry.data_byte = r_k;
        wr_entry.code      = r_next_free[CODE_W-1:0];
        ram_we             = 1'b0;
        ram_waddr          = r_slot;
        if (r_state == S_CLEAR) begin
            wr_entry  = '0;
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
        end else if (r_state == S_CHECK) begin
            ram_we = slot_free && can_insert;
        end
    end

    lzwh_ram #(
        .WIDTH (EW),
        .DEPTH (HASH_ENTRIES)
    ) u_dict (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_epoch     <= EPOCH_W'(1);
            r_shamt     <= RST_SHAMT;
            r_size      <= RST_SIZE;
            r_limit     <= RST_LIMIT;
            r_prefix    <= '0;
            r_have      <= 1'b0;
            r_next_free <= FREE_CODE_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_shamt     <= lzwh_pkg::hash_shift(cfg_eff);
                r_size      <= cfg_size;
                r_limit     <= lzwh_pkg::code_limit(cfg_eff);
                r_prefix    <= '0;
                r_have      <= 1'b0;
                r_next_free <= FREE_CODE_INIT;
                if (r_state != S_CLEAR) begin
                    if (epoch_wrap) begin
                        r_state    <= S_CLEAR;
                        r_clr_addr <= '0;
                        r_epoch    <= EPOCH_W'(1);
                    end else begin
                        r_state <= S_IDLE;
                        r_epoch <= r_epoch + EPOCH_W'(1);
                    end
                end
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                        if (r_clr_addr == LAST_ADDR) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_in_valid) begin
                            r_k    <= i_data_byte;
                            r_last <= i_end_of_data;
                            if (!r_have) begin
                                r_prefix <= CODE_W'(i_data_byte);
                                r_have   <= 1'b1;
                                if (i_end_of_data) begin
                                    r_state <= S_FINAL;
                                end
                            end else begin
                                r_h <= hash_v;
                                r_n <= '0;
                                if (hash_fits) begin
                                    r_slot  <= AW'(hash_v);
                                    r_state <= S_READ;
                                end else begin
                                    r_rem   <= '0;
                                    r_mcnt  <= MCNT_W'(CODE_W - 1);
                                    r_state <= S_MOD;
                                end
                            end
                        end
                    end
                    S_MOD: begin
                        r_rem  <= n_rem;
                        r_mcnt <= r_mcnt - MCNT_W'(1);
                        if (r_mcnt == '0) begin
                            r_slot  <= AW'(n_rem);
                            r_state <= S_READ;
                        end
                    end
                    S_READ: begin
                        if (r_n == '0) begin
                            r_step <= (r_slot == '0) ? AW'(1) : sub_diff[AW-1:0];
                        end
                        r_state <= S_CHECK;
                    end
                    S_CHECK: begin
                        if (slot_free || (!slot_hit && n_n == r_size)) begin
                            if (slot_free && can_insert) begin
                                r_next_free <= r_next_free + NEXT_W'(1);
                            end
                            r_emit_code <= r_prefix;
                            r_prefix    <= CODE_W'(r_k);
                            r_state     <= S_EMIT;
                        end else if (slot_hit) begin
                            r_prefix <= rd_entry.code;
                            r_state  <= r_last ? S_FINAL : S_IDLE;
                        end else begin
                            r_n     <= n_n;
                            r_slot  <= n_slot;
                            r_state <= S_READ;
                        end
                    end
                    S_EMIT: begin
                        if (can_load) begin
                            r_out_code  <= r_emit_code;
                            r_out_final <= 1'b0;
                            r_state     <= r_last ? S_FINAL : S_IDLE;
                        end
                    end
                    S_FINAL: begin
                        if (can_load) begin
                            r_out_code  <= r_prefix;
                            r_out_final <= 1'b1;
                            r_prefix    <= '0;
                            r_have      <= 1'b0;
                            r_next_free <= FREE_CODE_INIT;
                            // drop the dictionary: new epoch, or clearing pass on wrap
                            if (epoch_wrap) begin
                                r_state    <= S_CLEAR;
                                r_clr_addr <= '0;
                                r_epoch    <= EPOCH_W'(1);
                            end else begin
                                r_state <= S_IDLE;
                                r_epoch <= r_epoch + EPOCH_W'(1);
                            end
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_in_stall   = r_state != S_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_code_out   = r_out_code;
    assign o_final_code = r_out_final;

endmodule

`default_nettype wire

/* hdl/lzwh_checker.sv */
// Port-level assertions for the LZW hash compressor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lzwh_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_in_valid,
    input  logic                        o_in_stall,
    input  logic                        i_end_of_data,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic [lzwh_pkg::CODE_W-1:0] o_code_out,
    input  logic                        o_final_code
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_code_out) && $stable(o_final_code))
        else $error("output word changed while stalled");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_end_of_data && !i_cfg_we |=> o_in_stall)
        else $error("last byte accepted without a pending final code");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("block not in clearing pass after reset");

endmodule

bind lzw_hash_compressor lzwh_checker u_lzwh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_end_of_data (i_end_of_data),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_code_out    (o_code_out),
    .o_final_code  (o_final_code)
);

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the LZW hash compressor: streams of bytes in, LZW codes out.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned HASH_SLOTS   = lzwh_pkg::HASH_ENTRIES_DEF;
    localparam int unsigned FREE_CODE_INIT = lzwh_pkg::FIRST_FREE_DEF;
    localparam int unsigned SLOTS_BY_BITS [8] =
        '{641, 1259, 2459, 4919, 9833, 19661, 39323, 78649};
    localparam int          PHASE_WORDS  = 210;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          CYCLE_LIMIT  = 3000000;

    typedef struct packed {
        logic [lzwh_pkg::BYTE_W-1:0] data;
        logic                        last;
    } t_byte_word;

    typedef struct packed {
        logic [lzwh_pkg::CODE_W-1:0] code;
        logic                        final_flag;
    } t_code_word;

    typedef enum int {
        IDLE_SENDER_LIGHT,
        IDLE_RECEIVER_LIGHT,
        IDLE_NONE
    } t_idle_mode;

    typedef enum int {
        FLAVOR_WIDE,
        FLAVOR_NARROW,
        FLAVOR_REPEAT
    } t_stream_flavor;

    logic                          i_clk;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [lzwh_pkg::BITS_W-1:0]   i_cfg_data    = '0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_stall;
    logic [lzwh_pkg::BYTE_W-1:0]   i_data_byte   = '0;
    logic                          i_end_of_data = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall   = 1'b0;
    logic [lzwh_pkg::CODE_W-1:0]   o_code_out;
    logic                          o_final_code;

    lzw_hash_compressor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_out    (o_code_out),
        .o_final_code  (o_final_code)
    );

    t_byte_word byte_words [$];
    t_code_word codes_due [$];
    int         words_queued = 0;
    int         words_taken  = 0;
    int         mismatches   = 0;
    int         cycle_count  = 0;
    int         tx_idle_pct  = 14;
    int         rx_stall_pct = 50;

    // dictionary model; a slot is live when its epoch matches the current one
    logic [lzwh_pkg::BITS_W-1:0] code_bits_reg = lzwh_pkg::BITS_RESET;
    logic [lzwh_pkg::CODE_W-1:0] cur_prefix    = '0;
    bit                          prefix_open   = 1'b0;
    int unsigned                 free_code     = FREE_CODE_INIT;
    int unsigned                 dict_epoch    = 1;
    int unsigned                 slot_epoch  [HASH_SLOTS];
    logic [lzwh_pkg::CODE_W-1:0] slot_prefix [HASH_SLOTS];
    logic [lzwh_pkg::BYTE_W-1:0] slot_byte   [HASH_SLOTS];
    logic [lzwh_pkg::CODE_W-1:0] slot_code   [HASH_SLOTS];

    function automatic void restart_stream();
        cur_prefix  = '0;
        prefix_open = 1'b0;
        free_code   = FREE_CODE_INIT;
        dict_epoch++;
    endfunction

    function automatic void lzw_predict(input logic [lzwh_pkg::BYTE_W-1:0] k, input logic last);
        int unsigned bits;
        int unsigned tbl_size;
        int unsigned limit;
        int unsigned slot;
        int unsigned step;
        int unsigned n;
        bit          free_found;
        bit          hit;
        t_code_word  cw;
        if (!prefix_open) begin
            cur_prefix  = lzwh_pkg::CODE_W'(k);
            prefix_open = 1'b1;
        end else begin
            bits = 32'(code_bits_reg);
            if (bits < 32'(lzwh_pkg::BITS_MIN)) bits = 32'(lzwh_pkg::BITS_MIN);
            if (bits > 32'(lzwh_pkg::BITS_MAX)) bits = 32'(lzwh_pkg::BITS_MAX);
            tbl_size = SLOTS_BY_BITS[bits - 9];
            if (tbl_size > HASH_SLOTS) tbl_size = HASH_SLOTS;
            limit = (32'd1 << bits) - 1;
            slot  = ((32'(k) << (bits - 8)) ^ 32'(cur_prefix)) % tbl_size;
            step  = (slot == 0) ? 1 : tbl_size - slot;
            step  = step % tbl_size;
            free_found = 1'b0;
            hit        = 1'b0;
            for (n = 0; n < tbl_size && !free_found && !hit; n++) begin
                if (slot_epoch[slot] != dict_epoch) begin
                    free_found = 1'b1;
                end else if (slot_prefix[slot] == cur_prefix && slot_byte[slot] == k) begin
                    hit = 1'b1;
                end else begin
                    slot = (slot >= step) ? slot - step : slot + tbl_size - step;
                end
            end
            if (hit) begin
                cur_prefix = slot_code[slot];
            end else begin
                cw.code       = cur_prefix;
                cw.final_flag = 1'b0;
                codes_due.push_back(cw);
                if (free_found && free_code < limit) begin
                    slot_epoch[slot]  = dict_epoch;
                    slot_prefix[slot] = cur_prefix;
                    slot_byte[slot]   = k;
                    slot_code[slot]   = lzwh_pkg::CODE_W'(free_code);
                    free_code++;
                end
                cur_prefix = lzwh_pkg::CODE_W'(k);
            end
        end
        if (last) begin
            cw.code       = cur_prefix;
            cw.final_flag = 1'b1;
            codes_due.push_back(cw);
            restart_stream();
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // byte driver: predict on acceptance, then present the next word or idle
    always @(posedge i_clk) begin
        t_byte_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                lzw_predict(i_data_byte, i_end_of_data);
                words_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (byte_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    w = byte_words.pop_front();
                    i_in_valid    <= 1'b1;
                    i_data_byte   <= w.data;
                    i_end_of_data <= w.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // code monitor
    always @(posedge i_clk) begin
        t_code_word cw;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (codes_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected code word: code %0d final %0b",
                                 o_code_out, o_final_code);
                    end
                    mismatches++;
                end else begin
                    cw = codes_due.pop_front();
                    if (o_code_out !== cw.code || o_final_code !== cw.final_flag) begin
                        if (mismatches < 10) begin
                            $display({"code mismatch: expected code %0d final %0b, ",
                                      "got code %0d final %0b"},
                                     cw.code, cw.final_flag, o_code_out, o_final_code);
                        end
                        mismatches++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_SENDER_LIGHT: begin
                tx_idle_pct  = 14;
                rx_stall_pct = 50;
            end
            IDLE_RECEIVER_LIGHT: begin
                tx_idle_pct  = 50;
                rx_stall_pct = 14;
            end
            default: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
        endcase
    endtask

    task automatic queue_word(input logic [lzwh_pkg::BYTE_W-1:0] data, input logic last);
        t_byte_word w;
        w.data = data;
        w.last = last;
        byte_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_stream(input int len, input t_stream_flavor flavor, input bit close);
        logic [lzwh_pkg::BYTE_W-1:0] pattern [5];
        logic [lzwh_pkg::BYTE_W-1:0] base;
        logic [lzwh_pkg::BYTE_W-1:0] b;
        int period;
        base   = lzwh_pkg::BYTE_W'($urandom_range(255));
        period = $urandom_range(5, 1);
        foreach (pattern[j]) pattern[j] = lzwh_pkg::BYTE_W'($urandom_range(255));
        for (int i = 0; i < len; i++) begin
            case (flavor)
                FLAVOR_WIDE:   b = lzwh_pkg::BYTE_W'($urandom_range(255));
                FLAVOR_NARROW: b = base ^ lzwh_pkg::BYTE_W'($urandom_range(3));
                default:       b = pattern[i % period];
            endcase
            queue_word(b, close && (i == len - 1));
        end
    endtask

    task automatic wait_drained();
        while (words_taken != words_queued || codes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_code_bits(input logic [lzwh_pkg::BITS_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        code_bits_reg = value;
        restart_stream();
    endtask

    task automatic run_phase(input logic [lzwh_pkg::BITS_W-1:0] bits_val, input t_idle_mode mode,
                             input int fill_len, input bit open_tail);
        int target;
        int len;
        int pick;
        write_code_bits(bits_val);
        set_idle(mode);
        if (fill_len != 0) queue_stream(fill_len, FLAVOR_WIDE, 1'b1);
        target = words_queued + PHASE_WORDS;
        while (words_queued < target) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                len = 1;
            end else if (pick < 90) begin
                len = $urandom_range(48, 2);
            end else begin
                len = $urandom_range(200, 60);
            end
            queue_stream(len, t_stream_flavor'($urandom_range(2)), 1'b1);
        end
        if (open_tail) begin
            queue_stream($urandom_range(20, 5), t_stream_flavor'($urandom_range(2)), 1'b0);
        end
    endtask

    initial begin
        set_idle(IDLE_SENDER_LIGHT);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_word(8'h00, 1'b1);
        queue_word(8'hFF, 1'b1);
        queue_stream(0, FLAVOR_WIDE, 1'b1);
        for (int i = 0; i < 7; i++) queue_word((i % 2 == 0) ? 8'h41 : 8'h42, i == 6);
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b1);
        for (int i = 0; i < 7; i++) queue_word(8'hFF, i == 6);
        queue_word(8'h80, 1'b0);
        queue_word(8'h7F, 1'b1);
        queue_word(8'h55, 1'b0);
        queue_word(8'hAA, 1'b1);

        run_phase(lzwh_pkg::BITS_MIN, IDLE_SENDER_LIGHT, 400, 1'b0);
        run_phase(5'd0, IDLE_SENDER_LIGHT, 0, 1'b0);
        run_phase(5'd31, IDLE_RECEIVER_LIGHT, 0, 1'b0);
        run_phase(lzwh_pkg::BITS_MAX, IDLE_RECEIVER_LIGHT, 0, 1'b1);
        run_phase(lzwh_pkg::BITS_W'($urandom_range(16, 9)), IDLE_NONE, 0, 1'b0);
        run_phase(lzwh_pkg::BITS_W'($urandom_range(31)), IDLE_NONE, 0, 1'b1);

        wait_drained();
        if (mismatches == 0 && codes_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
